// ----- src/pscm_pkg.sv -----
// ============================================================================
// pscm_pkg - shared types and constants for the patch SSD corner matcher
// Field widths, opcodes, register indexes, item structs and score helpers.
// ============================================================================
package pscm_pkg;

  localparam int CRD_W   = 12;
  localparam int RNG_W   = 8;
  localparam int PIX_W   = 8;
  localparam int IDX_W   = 7;
  localparam int SUM_W   = 23;
  localparam int DIM_W   = 13;
  localparam int SQ_W    = 2 * PIX_W;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam int HALF_PATCH_DEF = 4;

  localparam logic [SUM_W-1:0] SUM_MAX     = {SUM_W{1'b1}};
  localparam logic [SUM_W-1:0] MAX_SSD_RST = SUM_W'(9999);
  localparam logic [DIM_W-1:0] WIDTH_RST   = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RST  = DIM_W'(480);

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_BEGIN  = 2'd1,
    OP_CORNER = 2'd2,
    OP_FINISH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_MAX_SSD = 2'd0,
    REG_WIDTH   = 2'd1,
    REG_HEIGHT  = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    op_t              opcode;
    logic [CRD_W-1:0] coord_x;
    logic [CRD_W-1:0] coord_y;
    logic [RNG_W-1:0] search_range;
    logic [PIX_W-1:0] pixel;
    logic [IDX_W-1:0] pixel_index;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [CRD_W-1:0] best_x;
    logic [CRD_W-1:0] best_y;
    logic [SUM_W-1:0] best_score;
  } out_item_t;

  typedef struct packed {
    logic [SUM_W-1:0] max_ssd;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
  } cfg_t;

  // Score given to a rejected corner: max_ssd + 1, saturated.
  function automatic logic [SUM_W-1:0] reject_score(input logic [SUM_W-1:0] max_ssd);
    logic [SUM_W:0] s;
    s = {1'b0, max_ssd} + (SUM_W+1)'(1);
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage

// ----- src/pscm_if.sv -----
// ============================================================================
// pscm_if - request and result channels of the patch SSD corner matcher
// Valid/ready channels carrying the request fields and the result fields.
// ============================================================================
interface pscm_req_if
  import pscm_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [1:0]       opcode;
  logic [CRD_W-1:0] coord_x;
  logic [CRD_W-1:0] coord_y;
  logic [RNG_W-1:0] search_range;
  logic [PIX_W-1:0] pixel;
  logic [IDX_W-1:0] pixel_index;

  modport source (
    output valid, opcode, coord_x, coord_y, search_range, pixel, pixel_index,
    input  ready
  );
  modport sink (
    input  valid, opcode, coord_x, coord_y, search_range, pixel, pixel_index,
    output ready
  );
endinterface

interface pscm_rsp_if
  import pscm_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [CRD_W-1:0] best_x;
  logic [CRD_W-1:0] best_y;
  logic [SUM_W-1:0] best_score;

  modport source (
    output valid, found, best_x, best_y, best_score,
    input  ready
  );
  modport sink (
    input  valid, found, best_x, best_y, best_score,
    output ready
  );
endinterface

// ----- src/pscm_cfg.sv -----
// ============================================================================
// pscm_cfg - configuration registers
// APB-style register file holding max_ssd and the image dimensions.
// ============================================================================
module pscm_cfg
  import pscm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  cfg_t     regs;
  reg_idx_t sel;
  logic     wr;

  assign pready = 1'b1;
  assign sel    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr     = psel && penable && pwrite && pready;
  assign cfg    = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.max_ssd      <= MAX_SSD_RST;
      regs.image_width  <= WIDTH_RST;
      regs.image_height <= HEIGHT_RST;
    end else if (wr) begin
      unique case (sel)
        REG_MAX_SSD: regs.max_ssd      <= pwdata[SUM_W-1:0];
        REG_WIDTH:   regs.image_width  <= pwdata[DIM_W-1:0];
        REG_HEIGHT:  regs.image_height <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_MAX_SSD: prdata = PDATA_W'(regs.max_ssd);
      REG_WIDTH:   prdata = PDATA_W'(regs.image_width);
      REG_HEIGHT:  prdata = PDATA_W'(regs.image_height);
      default:     prdata = '0;
    endcase
  end

endmodule

// ----- src/pscm_tmpl_mem.sv -----
// ============================================================================
// pscm_tmpl_mem - template pixel store
// One write port, one registered read port.
// ============================================================================
module pscm_tmpl_mem
  import pscm_pkg::*;
#(
  parameter int DEPTH  = 81,
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [PIX_W-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [PIX_W-1:0]  rdata
);

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/pscm_score.sv -----
// ============================================================================
// pscm_score - SSD accumulation, best-match tracking and result register
// Squares one pixel difference per item, keeps the running sum and the
// best corner, and loads the result register on a finish request.
// ============================================================================
module pscm_score
  import pscm_pkg::*;
#(
  parameter int HALF_PATCH = HALF_PATCH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  in_item_t         item,
  input  logic [PIX_W-1:0] tmpl,
  input  cfg_t             cfg,
  input  logic             rsp_ready,
  output logic             rsp_valid,
  output out_item_t        rsp_item,
  output logic             rsp_busy
);

  localparam int PATCH_SIDE = 2 * HALF_PATCH + 1;
  localparam int PATCH_AREA = PATCH_SIDE * PATCH_SIDE;
  localparam int LAST_IDX   = PATCH_AREA - 1;

  logic [CRD_W-1:0] centre_x, centre_y;
  logic [RNG_W-1:0] box_range;
  logic [SUM_W-1:0] running_sum, best_sum;
  logic [CRD_W-1:0] best_pos_x, best_pos_y;

  logic signed [PIX_W:0]     diff;
  logic signed [2*PIX_W+1:0] sq_full;
  logic [SQ_W-1:0]           sq;
  logic [SUM_W-1:0]          base, sum, reject, score;
  logic [SUM_W:0]            sum_wide;
  logic                      idx_ok, is_last, in_box, in_image, corner_ok, found;
  logic [CRD_W:0]            x_e, y_e, cx_e, cy_e, r_e;

  assign reject  = reject_score(cfg.max_ssd);
  assign idx_ok  = 32'(item.pixel_index) < 32'(PATCH_AREA);
  assign is_last = 32'(item.pixel_index) == 32'(LAST_IDX);

  assign diff     = $signed({1'b0, item.pixel}) - $signed({1'b0, tmpl});
  assign sq_full  = diff * diff;
  assign sq       = sq_full[SQ_W-1:0];
  assign base     = (item.pixel_index == '0) ? '0 : running_sum;
  assign sum_wide = {1'b0, base} + (SUM_W+1)'(sq);
  assign sum      = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

  // Search box, bounds inclusive.
  assign x_e  = {1'b0, item.coord_x};
  assign y_e  = {1'b0, item.coord_y};
  assign cx_e = {1'b0, centre_x};
  assign cy_e = {1'b0, centre_y};
  assign r_e  = (CRD_W+1)'(box_range);
  assign in_box = (x_e + r_e >= cx_e) && (x_e <= cx_e + r_e) &&
                  (y_e + r_e >= cy_e) && (y_e <= cy_e + r_e);

  // Patch must fit: x >= HALF_PATCH and x + HALF_PATCH < width.
  assign in_image =
    (item.coord_x >= CRD_W'(HALF_PATCH)) && (item.coord_y >= CRD_W'(HALF_PATCH)) &&
    ((DIM_W+1)'(item.coord_x) + (DIM_W+1)'(HALF_PATCH) < (DIM_W+1)'(cfg.image_width)) &&
    ((DIM_W+1)'(item.coord_y) + (DIM_W+1)'(HALF_PATCH) < (DIM_W+1)'(cfg.image_height));

  assign corner_ok = in_box && in_image;
  assign score     = corner_ok ? sum : reject;
  assign found     = best_sum < cfg.max_ssd;
  assign rsp_busy  = rsp_valid && !rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_x    <= '0;
      centre_y    <= '0;
      box_range   <= '0;
      running_sum <= '0;
      best_sum    <= reject_score(MAX_SSD_RST);
      best_pos_x  <= '0;
      best_pos_y  <= '0;
    end else if (fire) begin
      unique case (item.opcode)
        OP_BEGIN: begin
          centre_x    <= item.coord_x;
          centre_y    <= item.coord_y;
          box_range   <= item.search_range;
          running_sum <= '0;
          best_sum    <= reject;
          best_pos_x  <= '0;
          best_pos_y  <= '0;
        end
        OP_CORNER: begin
          if (idx_ok) begin
            running_sum <= sum;
            if (is_last && (score < best_sum)) begin
              best_sum   <= score;
              best_pos_x <= item.coord_x;
              best_pos_y <= item.coord_y;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire && (item.opcode == OP_FINISH)) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (item.opcode == OP_FINISH)) begin
      rsp_item.found      <= found;
      rsp_item.best_x     <= found ? best_pos_x : '0;
      rsp_item.best_y     <= found ? best_pos_y : '0;
      rsp_item.best_score <= best_sum;
    end
  end

endmodule

// ----- src/patch_ssd_corner_matcher.sv -----
// ============================================================================
// patch_ssd_corner_matcher - SSD template matcher for corner patches
// Scores candidate corners against a stored square template by sum of
// squared differences and reports the best corner inside a search box.
// ============================================================================
//
//  channel | dir | handshake          | carries
//  --------+-----+--------------------+------------------------------------------
//  req     | in  | valid / ready      | opcode, coord_x/y, search_range, pixel,
//          |     |                    | pixel_index
//  rsp     | out | valid / ready      | found, best_x, best_y, best_score
//  apb     | in  | psel/penable/pready| max_ssd (0x0), image_width (0x4),
//          |     |                    | image_height (0x8)
//
//  Throughput is one request per cycle while no finish request is held;
//  each request passes an input register, a template read stage and the
//  single subtract-square-add stage; a finish loads the result register.
//  Reset is synchronous; there is no clearing pass, and the template store
//  holds nothing valid until its entries are loaded.
//  Only a finish request that meets a result still waiting in the result
//  register holds the pipeline; every other request flows on.
//
module patch_ssd_corner_matcher
  import pscm_pkg::*;
#(
  parameter int HALF_PATCH = HALF_PATCH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  pscm_req_if.sink           req,
  pscm_rsp_if.source         rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int PATCH_SIDE = 2 * HALF_PATCH + 1;
  localparam int PATCH_AREA = PATCH_SIDE * PATCH_SIDE;
  localparam int ADDR_W     = $clog2(PATCH_AREA);

  cfg_t             cfg;
  in_item_t         req_item;
  logic             s1_valid, s2_valid;
  in_item_t         s1, s2;
  logic             s2_hold, s2_free, s1_free, s1_adv, s2_fire, req_take;
  logic             rsp_busy;
  logic [PIX_W-1:0] tmpl;
  out_item_t        rsp_item;
  logic             tmpl_we;

  // Gather the request fields into one item.
  assign req_item.opcode       = op_t'(req.opcode);
  assign req_item.coord_x      = req.coord_x;
  assign req_item.coord_y      = req.coord_y;
  assign req_item.search_range = req.search_range;
  assign req_item.pixel        = req.pixel;
  assign req_item.pixel_index  = req.pixel_index;

  // Pipeline control: only a finish facing a full result register holds.
  assign s2_hold  = s2_valid && (s2.opcode == OP_FINISH) && rsp_busy;
  assign s2_fire  = s2_valid && !s2_hold;
  assign s2_free  = !s2_hold;
  assign s1_adv   = s1_valid && s2_free;
  assign s1_free  = !s1_valid || s2_free;
  assign req.ready = s1_free;
  assign req_take  = req.valid && s1_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      s1 <= req_item;
    end
  end

  // Template read stage: the read lands alongside the item in stage two.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2 <= s1;
    end
  end

  // Drop template loads whose index lies outside the patch.
  assign tmpl_we = s1_adv && (s1.opcode == OP_LOAD) &&
                   (32'(s1.pixel_index) < 32'(PATCH_AREA));

  pscm_tmpl_mem #(
    .DEPTH  (PATCH_AREA),
    .ADDR_W (ADDR_W)
  ) u_tmpl_mem (
    .clk   (clk),
    .we    (tmpl_we),
    .waddr (ADDR_W'(s1.pixel_index)),
    .wdata (s1.pixel),
    .re    (s1_adv),
    .raddr (ADDR_W'(s1.pixel_index)),
    .rdata (tmpl)
  );

  pscm_score #(
    .HALF_PATCH (HALF_PATCH)
  ) u_score (
    .clk       (clk),
    .rst       (rst),
    .fire      (s2_fire),
    .item      (s2),
    .tmpl      (tmpl),
    .cfg       (cfg),
    .rsp_ready (rsp.ready),
    .rsp_valid (rsp.valid),
    .rsp_item  (rsp_item),
    .rsp_busy  (rsp_busy)
  );

  assign rsp.found      = rsp_item.found;
  assign rsp.best_x     = rsp_item.best_x;
  assign rsp.best_y     = rsp_item.best_y;
  assign rsp.best_score = rsp_item.best_score;

  pscm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

endmodule

// ----- src/pscm_checker.sv -----
// ============================================================================
// pscm_checker - port-level checks for the patch SSD corner matcher
// Watches the result channel over time; bound to the top level.
// ============================================================================
module pscm_checker
  import pscm_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic             found,
  input logic [CRD_W-1:0] best_x,
  input logic [CRD_W-1:0] best_y,
  input logic [SUM_W-1:0] best_score
);

  // Hold a waiting result until it is taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped before it was taken");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=>
      $stable(found) && $stable(best_x) && $stable(best_y) && $stable(best_score))
    else $error("waiting result changed");

  // No match reports a zero position.
  a_nomatch_pos: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !found |-> (best_x == '0) && (best_y == '0))
    else $error("position reported without a match");

  // A match lies strictly below max_ssd, so it never carries the ceiling.
  a_match_score: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && found |-> best_score != SUM_MAX)
    else $error("match reported with saturated score");

endmodule

bind patch_ssd_corner_matcher pscm_checker u_pscm_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .found      (rsp.found),
  .best_x     (rsp.best_x),
  .best_y     (rsp.best_y),
  .best_score (rsp.best_score)
);

// ----- tb/tb_patch_ssd_corner_matcher.sv -----
// ============================================================================
// tb_patch_ssd_corner_matcher - self-checking bench for the SSD corner matcher
// Loads a template, walks a short table of directed requests, then runs
// randomised search sequences across several register settings. Every finish
// result is checked field by field against the table or a score predictor.
// ============================================================================
module tb_patch_ssd_corner_matcher;
  import pscm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HP          = HALF_PATCH_DEF;
  localparam int SIDE        = 2 * HP + 1;
  localparam int AREA        = SIDE * SIDE;
  localparam int LAST        = AREA - 1;
  localparam int CRD_MAX     = (1 << CRD_W) - 1;
  localparam int ITEMS       = 450;
  localparam int SETTLE      = 8;
  localparam int SAT_RUN     = 129;

  // Shapes of a corner burst; PAT_SINGLE marks a plain one-request row.
  typedef enum logic [3:0] {
    PAT_SINGLE, PAT_EXACT, PAT_INVERT, PAT_CONST, PAT_NEAR,
    PAT_NOISE, PAT_SHUFFLE, PAT_TRUNC, PAT_PADDED, PAT_SAT
  } pat_t;

  typedef struct packed {
    op_t              op;
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
    logic [RNG_W-1:0] rng;
    logic [PIX_W-1:0] pix;
    logic [IDX_W-1:0] idx;
    pat_t             pat;
    logic             typed;
    out_item_t        want;
  } vec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sink_ready = 1'b0;

  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  pscm_req_if req_ch ();
  pscm_rsp_if rsp_ch ();

  assign rsp_ch.ready = sink_ready;

  patch_ssd_corner_matcher #(
    .HALF_PATCH (HP)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: shadow registers and the matcher's own search state
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0] max_ssd_r;
  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;

  logic [PIX_W-1:0] tmpl [0:LAST];
  logic [CRD_W-1:0] centre_x;
  logic [CRD_W-1:0] centre_y;
  logic [RNG_W-1:0] box_range;
  logic [SUM_W-1:0] running_ssd;
  logic [SUM_W-1:0] best_ssd;
  logic [CRD_W-1:0] best_px;
  logic [CRD_W-1:0] best_py;

  out_item_t match_q [$];
  vec_t      dir_tab [$];

  int  n_err    = 0;
  int  n_req    = 0;
  bit  calm     = 1'b0;
  int unsigned ready_hold = 0;

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int clip_coord(input int v);
    if (v < 0) return 0;
    if (v > CRD_MAX) return CRD_MAX;
    return v;
  endfunction

  function automatic string fmt_match(input out_item_t m);
    return $sformatf("found=%0d x=%0d y=%0d score=%0d",
                     m.found, m.best_x, m.best_y, m.best_score);
  endfunction

  function automatic void note_fail(input string msg);
    n_err++;
    if (n_err <= 10) $display("%0t ns: %s", $time, msg);
  endfunction

  function automatic out_item_t match_of(input bit f, input int x, input int y,
                                         input int score);
    out_item_t m;
    m.found      = f;
    m.best_x     = CRD_W'(x);
    m.best_y     = CRD_W'(y);
    m.best_score = SUM_W'(score);
    return m;
  endfunction

  function automatic vec_t vrow(input op_t op, input int x, input int y, input int rng,
                                input int pix, input int idx, input pat_t pat = PAT_SINGLE,
                                input bit typed = 1'b0, input out_item_t want = '0);
    vec_t v;
    v.op    = op;
    v.x     = CRD_W'(x);
    v.y     = CRD_W'(y);
    v.rng   = RNG_W'(rng);
    v.pix   = PIX_W'(pix);
    v.idx   = IDX_W'(idx);
    v.pat   = pat;
    v.typed = typed;
    v.want  = want;
    return v;
  endfunction

  // Fill every field at random so that unused fields toggle too.
  function automatic in_item_t random_request(input op_t op);
    in_item_t r;
    r.opcode       = op;
    r.coord_x      = CRD_W'($urandom);
    r.coord_y      = CRD_W'($urandom);
    r.search_range = RNG_W'($urandom);
    r.pixel        = PIX_W'($urandom);
    r.pixel_index  = IDX_W'($urandom);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Score predictor
  // --------------------------------------------------------------------------
  function automatic logic [SUM_W-1:0] rejection();
    return (max_ssd_r == SUM_MAX) ? SUM_MAX : max_ssd_r + SUM_W'(1);
  endfunction

  // Inside the search box (bounds inclusive) and clear of every image edge.
  function automatic bit corner_ok(input int x, input int y);
    int cx, cy, r, w, h;
    cx = int'(centre_x);
    cy = int'(centre_y);
    r  = int'(box_range);
    w  = int'(width_r);
    h  = int'(height_r);
    if (x < cx - r || x > cx + r || y < cy - r || y > cy + r) return 1'b0;
    if (x < HP || y < HP) return 1'b0;
    if (x >= w - HP || y >= h - HP) return 1'b0;
    return 1'b1;
  endfunction

  task automatic predict_match(input in_item_t r, output bit has_res, output out_item_t res);
    int             d;
    logic [SUM_W:0] acc;
    logic [SUM_W-1:0] score;
    has_res = 1'b0;
    res     = '0;
    case (r.opcode)
      OP_LOAD: begin
        if (r.pixel_index < AREA) tmpl[r.pixel_index] = r.pixel;
      end
      OP_BEGIN: begin
        centre_x    = r.coord_x;
        centre_y    = r.coord_y;
        box_range   = r.search_range;
        running_ssd = '0;
        best_ssd    = rejection();
        best_px     = '0;
        best_py     = '0;
      end
      OP_CORNER: begin
        if (r.pixel_index < AREA) begin
          d   = int'(r.pixel) - int'(tmpl[r.pixel_index]);
          // index 0 opens a new corner; every other index adds on
          acc = (r.pixel_index == 0) ? '0 : {1'b0, running_ssd};
          acc = acc + (SUM_W+1)'(d * d);
          running_ssd = (acc > {1'b0, SUM_MAX}) ? SUM_MAX : acc[SUM_W-1:0];
          if (r.pixel_index == LAST) begin
            score = corner_ok(int'(r.coord_x), int'(r.coord_y)) ? running_ssd : rejection();
            if (score < best_ssd) begin
              best_ssd = score;
              best_px  = r.coord_x;
              best_py  = r.coord_y;
            end
          end
        end
      end
      default: begin
        has_res        = 1'b1;
        res.found      = best_ssd < max_ssd_r;
        res.best_x     = res.found ? best_px : '0;
        res.best_y     = res.found ? best_py : '0;
        res.best_score = best_ssd;
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Request driver: random gap, hold valid until ready, then predict
  // --------------------------------------------------------------------------
  task automatic push_req(input in_item_t it, input bit typed = 1'b0,
                          input out_item_t want = '0);
    int unsigned gap;
    bit          has_res;
    out_item_t   res;
    gap = idle_len();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.opcode       <= it.opcode;
    req_ch.coord_x      <= it.coord_x;
    req_ch.coord_y      <= it.coord_y;
    req_ch.search_range <= it.search_range;
    req_ch.pixel        <= it.pixel;
    req_ch.pixel_index  <= it.pixel_index;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    predict_match(it, has_res, res);
    n_req++;
    if (has_res) match_q.push_back(typed ? want : res);
  endtask

  // Drive one candidate corner as a short burst of pixel requests; in most
  // shapes index 0 opens it, a few inner indices add on, the last completes it.
  task automatic push_corner(input int x, input int y, input pat_t pat,
                             input logic [PIX_W-1:0] cval);
    int        order [$];
    int        a, j, tmp, k;
    in_item_t  it;
    logic [PIX_W-1:0] t;
    case (pat)
      PAT_TRUNC: begin
        // never reaches the last index, so the corner stays open
        k = $urandom_range(1, 4);
        for (a = 0; a < k; a++) order.push_back(a);
      end
      PAT_PADDED: begin
        order.push_back(0);
        order.push_back($urandom_range(AREA, 127));
        order.push_back($urandom_range(1, LAST - 1));
        order.push_back($urandom_range(AREA, 127));
        order.push_back(LAST);
      end
      PAT_SAT: begin
        // with entry 1 at zero, SAT_RUN full-range steps and one step of 20
        // land just past the ceiling; a wrapping sum would end near zero
        order.push_back(0);
        repeat (SAT_RUN) order.push_back(1);
        order.push_back(2);
        order.push_back(AREA + 19);
        order.push_back(LAST);
      end
      default: begin
        order.push_back(0);
        k = $urandom_range(0, 5);
        repeat (k) order.push_back($urandom_range(1, LAST - 1));
        order.push_back(LAST);
      end
    endcase
    if (pat == PAT_SHUFFLE) begin
      for (a = order.size() - 1; a > 0; a--) begin
        j = $urandom_range(0, a);
        tmp = order[a];
        order[a] = order[j];
        order[j] = tmp;
      end
    end
    foreach (order[n]) begin
      it = random_request(OP_CORNER);
      it.coord_x     = CRD_W'(x);
      it.coord_y     = CRD_W'(y);
      it.pixel_index = IDX_W'(order[n]);
      if (order[n] < AREA) begin
        t = tmpl[order[n]];
        case (pat)
          PAT_EXACT:  it.pixel = t;
          PAT_INVERT: it.pixel = t[PIX_W-1] ? '0 : '1;
          PAT_CONST:  it.pixel = cval;
          PAT_NOISE:  ;
          PAT_SAT: begin
            if (order[n] == 1)      it.pixel = t[PIX_W-1] ? '0 : '1;
            else if (order[n] == 2) it.pixel = t[PIX_W-1] ? t - PIX_W'(20) : t + PIX_W'(20);
            else                    it.pixel = t;
          end
          default: begin
            k = int'(t) + int'($urandom_range(0, 6)) - 3;
            it.pixel = PIX_W'((k < 0) ? 0 : (k > 255) ? 255 : k);
          end
        endcase
      end
      push_req(it);
    end
  endtask

  // Candidate coordinate: mostly inside the current box, some on its edge,
  // some anywhere.
  function automatic int box_coord(input int c);
    int r;
    int unsigned sel;
    r   = int'(box_range);
    sel = $urandom_range(0, 7);
    if (sel == 0) return clip_coord($urandom_range(0, 1) ? c - r : c + r);
    if (sel == 1) return $urandom_range(0, CRD_MAX);
    return clip_coord(c + int'($urandom_range(0, 2 * r)) - r);
  endfunction

  function automatic pat_t pick_pattern();
    case ($urandom_range(0, 10))
      0, 1, 2, 3: return PAT_NEAR;
      4:          return PAT_EXACT;
      5:          return PAT_NOISE;
      6:          return PAT_SHUFFLE;
      7:          return PAT_TRUNC;
      8:          return PAT_PADDED;
      9:          return PAT_INVERT;
      default:    return PAT_CONST;
    endcase
  endfunction

  // One search: begin, a few corners with the odd stray request, a finish or two.
  task automatic run_search();
    in_item_t it;
    int       ncorner;
    it = random_request(OP_BEGIN);
    it.coord_x = CRD_W'($urandom_range(0, clip_coord(int'(width_r) + 4)));
    it.coord_y = CRD_W'($urandom_range(0, clip_coord(int'(height_r) + 4)));
    if ($urandom_range(0, 1)) it.search_range = RNG_W'($urandom_range(0, 8));
    push_req(it);
    ncorner = $urandom_range(0, 3);
    repeat (ncorner) begin
      push_corner(box_coord(int'(centre_x)), box_coord(int'(centre_y)), pick_pattern(),
                  PIX_W'($urandom));
      if ($urandom_range(0, 7) == 0) push_req(random_request(op_t'($urandom_range(0, 3))));
    end
    push_req(random_request(OP_FINISH));
    if ($urandom_range(0, 5) == 0) push_req(random_request(OP_FINISH));
  endtask

  // Drop valid, wait for every due result, then let the pipeline empty.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (match_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Register port
  // --------------------------------------------------------------------------
  task automatic reg_write(input reg_idx_t r, input logic [PDATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(r));
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (r)
      REG_MAX_SSD: max_ssd_r = v[SUM_W-1:0];
      REG_WIDTH:   width_r   = v[DIM_W-1:0];
      REG_HEIGHT:  height_r  = v[DIM_W-1:0];
      default:     ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [PDATA_W-1:0] shadow_of(input reg_idx_t r);
    case (r)
      REG_MAX_SSD: return PDATA_W'(max_ssd_r);
      REG_WIDTH:   return PDATA_W'(width_r);
      REG_HEIGHT:  return PDATA_W'(height_r);
      default:     return '0;
    endcase
  endfunction

  // Read back every register and compare with the shadow copy.
  task automatic check_regs();
    reg_idx_t          r;
    logic [PDATA_W-1:0] v;
    for (r = REG_MAX_SSD; r != REG_NONE; r = r.next()) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= PADDR_W'(4 * int'(r));
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (pready !== 1'b1);
      v = prdata;
      if (v !== shadow_of(r))
        note_fail($sformatf("register %s read %0d, expected %0d", r.name(), v, shadow_of(r)));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clk);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, then compare against the oldest due
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      sink_ready <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (calm) begin
      sink_ready <= 1'b1;
    end else if ($urandom_range(0, 1)) begin
      sink_ready <= 1'b1;
      ready_hold <= $urandom_range(0, 6);
    end else begin
      sink_ready <= 1'b0;
      ready_hold <= idle_len();
    end
  end

  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (!rst && rsp_ch.valid === 1'b1 && sink_ready) begin
      got.found      = rsp_ch.found;
      got.best_x     = rsp_ch.best_x;
      got.best_y     = rsp_ch.best_y;
      got.best_score = rsp_ch.best_score;
      if (match_q.size() == 0) begin
        note_fail($sformatf("unexpected result: %s", fmt_match(got)));
      end else begin
        want = match_q.pop_front();
        if (got.found !== want.found || got.best_x !== want.best_x ||
            got.best_y !== want.best_y || got.best_score !== want.best_score)
          note_fail($sformatf("mismatch: expected %s, got %s",
                              fmt_match(want), fmt_match(got)));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_item_t         it;
    vec_t             v;
    int               phase;
    logic [SUM_W-1:0] new_max;
    logic [DIM_W-1:0] new_w;
    logic [DIM_W-1:0] new_h;

    // hold the request channel quiet until reset is over
    req_ch.valid        <= 1'b0;
    req_ch.opcode       <= OP_LOAD;
    req_ch.coord_x      <= '0;
    req_ch.coord_y      <= '0;
    req_ch.search_range <= '0;
    req_ch.pixel        <= '0;
    req_ch.pixel_index  <= '0;

    max_ssd_r   = MAX_SSD_RST;
    width_r     = WIDTH_RST;
    height_r    = HEIGHT_RST;
    centre_x    = '0;
    centre_y    = '0;
    box_range   = '0;
    running_ssd = '0;
    best_ssd    = rejection();
    best_px     = '0;
    best_py     = '0;
    foreach (tmpl[i]) tmpl[i] = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_regs();

    // Load the whole template before any corner reads it.
    for (int i = 0; i < AREA; i++) begin
      it = random_request(OP_LOAD);
      it.pixel_index = IDX_W'(i);
      it.pixel       = PIX_W'(i * 29 + 7);
      push_req(it);
    end

    // Directed table: rows with a typed result check it directly, the rest
    // go through the predictor. Reset settings: max_ssd 9999, 640 x 480.
    dir_tab.push_back(vrow(OP_FINISH, 0, 0, 0, 0, 0, PAT_SINGLE, 1'b1,
                           match_of(0, 0, 0, 10000)));
    // loads beyond the patch are dropped
    dir_tab.push_back(vrow(OP_LOAD, 0, 0, 0, 8'hFF, AREA));
    dir_tab.push_back(vrow(OP_LOAD, 0, 0, 0, 8'hAA, 127));
    dir_tab.push_back(vrow(OP_LOAD, 0, 0, 0, 8'hFF, LAST));
    dir_tab.push_back(vrow(OP_LOAD, 0, 0, 0, 8'h00, 0));
    // entry 1 at zero gives the saturation run its full-range step
    dir_tab.push_back(vrow(OP_LOAD, 0, 0, 0, 8'h00, 1));
    // zero-size box: only the centre counts
    dir_tab.push_back(vrow(OP_BEGIN, 100, 100, 0, 0, 0));
    dir_tab.push_back(vrow(OP_CORNER, 100, 100, 0, 0, 0, PAT_EXACT));
    dir_tab.push_back(vrow(OP_FINISH, 0, 0, 0, 0, 0, PAT_SINGLE, 1'b1,
                           match_of(1, 100, 100, 0)));
    // finish leaves the search open; a corner outside the box changes nothing
    dir_tab.push_back(vrow(OP_CORNER, 101, 100, 0, 0, 0, PAT_EXACT));
    dir_tab.push_back(vrow(OP_FINISH, 0, 0, 0, 0, 0, PAT_SINGLE, 1'b1,
                           match_of(1, 100, 100, 0)));
    // far corner of the coordinate space, off the image
    dir_tab.push_back(vrow(OP_BEGIN, CRD_MAX, CRD_MAX, 255, 0, 0));
    dir_tab.push_back(vrow(OP_CORNER, CRD_MAX, CRD_MAX, 0, 0, 0, PAT_INVERT));
    dir_tab.push_back(vrow(OP_FINISH, 0, 0, 0, 0, 0, PAT_SINGLE, 1'b1,
                           match_of(0, 0, 0, 10000)));
    // left border, a real score, then a tie where the first match holds
    dir_tab.push_back(vrow(OP_BEGIN, 0, 0, 255, 0, 0));
    dir_tab.push_back(vrow(OP_CORNER, HP - 1, HP, 0, 0, 0, PAT_EXACT));
    dir_tab.push_back(vrow(OP_CORNER, HP, HP, 0, 0, 0, PAT_CONST));
    dir_tab.push_back(vrow(OP_CORNER, 250, 250, 0, 0, 0, PAT_EXACT));
    dir_tab.push_back(vrow(OP_CORNER, 251, 251, 0, 0, 0, PAT_EXACT));
    dir_tab.push_back(vrow(OP_FINISH, 0, 0, 0, 0, 0, PAT_SINGLE, 1'b1,
                           match_of(1, 250, 250, 0)));
    // saturating sum: a wrapped total would win here
    dir_tab.push_back(vrow(OP_BEGIN, 636, 475, 1, 0, 0));
    dir_tab.push_back(vrow(OP_CORNER, 635, 475, 0, 0, 0, PAT_SAT));
    dir_tab.push_back(vrow(OP_FINISH, 0, 0, 0, 0, 0, PAT_SINGLE, 1'b1,
                           match_of(0, 0, 0, 10000)));
    // restart at index 0, right border
    dir_tab.push_back(vrow(OP_CORNER, 635, 475, 0, 0, 0, PAT_EXACT));
    dir_tab.push_back(vrow(OP_CORNER, 636, 475, 0, 0, 0, PAT_EXACT));
    dir_tab.push_back(vrow(OP_FINISH, 0, 0, 0, 0, 0, PAT_SINGLE, 1'b1,
                           match_of(1, 635, 475, 0)));
    // indices in any order still add up
    dir_tab.push_back(vrow(OP_BEGIN, 320, 240, 255, 0, 0));
    dir_tab.push_back(vrow(OP_CORNER, 320, 240, 0, 0, 0, PAT_SHUFFLE));
    dir_tab.push_back(vrow(OP_FINISH, 0, 0, 0, 0, 0));

    foreach (dir_tab[i]) begin
      v = dir_tab[i];
      if (v.op == OP_CORNER && v.pat != PAT_SINGLE) begin
        push_corner(int'(v.x), int'(v.y), v.pat, v.pix);
      end else begin
        it.opcode       = v.op;
        it.coord_x      = v.x;
        it.coord_y      = v.y;
        it.search_range = v.rng;
        it.pixel        = v.pix;
        it.pixel_index  = v.idx;
        push_req(it, v.typed, v.want);
      end
    end
    drain();

    // Random phases: new register settings while idle, then search traffic.
    phase = 1;
    while (phase <= 4 || n_req < ITEMS) begin
      case (phase)
        1: begin
          new_max = SUM_W'(5267025);
          new_w   = DIM_W'(4096);
          new_h   = DIM_W'(4096);
        end
        2: begin
          // nothing can beat a limit of zero
          new_max = '0;
          new_w   = DIM_W'(4096);
          new_h   = DIM_W'(4096);
        end
        3: begin
          // a one-pixel image rejects every corner
          new_max = SUM_W'(5267025);
          new_w   = DIM_W'(1);
          new_h   = DIM_W'(1);
        end
        4: begin
          // smallest image that fits one patch
          new_max = SUM_W'($urandom_range(0, 20000));
          new_w   = DIM_W'(SIDE);
          new_h   = DIM_W'(SIDE);
        end
        default: begin
          case ($urandom_range(0, 2))
            0:       new_max = SUM_W'($urandom_range(0, 2000));
            1:       new_max = SUM_W'($urandom_range(1, 30000));
            default: new_max = SUM_W'($urandom_range(0, 5267025));
          endcase
          new_w = DIM_W'($urandom_range(0, 1) ? $urandom_range(SIDE, 700)
                                              : $urandom_range(1, 4096));
          new_h = DIM_W'($urandom_range(0, 1) ? $urandom_range(SIDE, 700)
                                              : $urandom_range(1, 4096));
        end
      endcase
      reg_write(REG_MAX_SSD, PDATA_W'(new_max));
      reg_write(REG_WIDTH, PDATA_W'(new_w));
      reg_write(REG_HEIGHT, PDATA_W'(new_h));
      check_regs();

      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) begin
        // refresh a few template entries in place
        repeat (4) begin
          it = random_request(OP_LOAD);
          it.pixel_index = IDX_W'($urandom_range(0, LAST));
          push_req(it);
        end
      end
      repeat ($urandom_range(2, 4)) run_search();
      drain();
      phase++;
    end

    calm = 1'b0;
    if (n_err == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
